// File: rtl/core/bb3_pkg.sv
// Shared types, widths and constants of the 3x3 box blur.
// No dependencies; used by bb3_mean and box_blur_3x3_rgb_unit.
package bb3_pkg;

    localparam int WIDTH_W     = 12;  // frame_width register
    localparam int HEIGHT_W    = 16;  // frame_height register
    localparam int PEND_W      = 13;  // outputs owed, up to width plus one
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int SUM_W       = 12;  // nine 8-bit values
    localparam int NUM_W       = 13;  // 2*sum + n
    localparam int CNT_W       = 4;   // neighbour count, 1 to 9
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 17;
    localparam int PROD_W      = NUM_W + RECIP_W;

    localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 12'd640;
    localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 16'd480;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // Indexed [row][column]; row 0 is the top row, column 0 the oldest column.
    typedef pixel_t [2:0][2:0] window_t;

    // Which window rows and columns lie inside the frame, and end of frame.
    typedef struct packed {
        logic [2:0] row_mask;
        logic [2:0] col_mask;
        logic       last;
    } mean_ctl_t;

    // ceil(2^17 / (2n)); exact floor division for every numerator below 4600.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] m;
        begin
            unique case (n)
                4'd2:    m = 17'd32768;
                4'd3:    m = 17'd21846;
                4'd4:    m = 17'd16384;
                4'd6:    m = 17'd10923;
                4'd9:    m = 17'd7282;
                default: m = 17'd65536;
            endcase
            return m;
        end
    endfunction

endpackage

// File: rtl/core/bb3_mean.sv
// Rounded neighbourhood mean of a 3x3 RGB window: sum stage, then divide stage.
// Depends on bb3_pkg (pixel and window types, control struct, reciprocal table).
module bb3_mean (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bb3_pkg::window_t    win,
    input  bb3_pkg::mean_ctl_t  ctl,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_red,
    output logic [7:0]          out_green,
    output logic [7:0]          out_blue,
    output logic                frame_last
);

    logic [bb3_pkg::SUM_W-1:0]   sum_red, sum_green, sum_blue;
    logic [1:0]                  row_cnt, col_cnt;
    logic [bb3_pkg::CNT_W-1:0]   n_cnt;

    logic                        s1_valid_reg;
    logic [bb3_pkg::SUM_W-1:0]   s1_red_reg, s1_green_reg, s1_blue_reg;
    logic [bb3_pkg::CNT_W-1:0]   s1_n_reg;
    logic [bb3_pkg::RECIP_W-1:0] s1_recip_reg;
    logic                        s1_last_reg;

    logic                        out_valid_reg;
    logic [7:0]                  out_red_reg, out_green_reg, out_blue_reg;
    logic                        out_last_reg;

    logic [bb3_pkg::NUM_W-1:0]   num_red, num_green, num_blue;
    logic [bb3_pkg::PROD_W-1:0]  prod_red, prod_green, prod_blue;
    logic                        out_load;

    // Sum the in-frame pixels of the window
    always_comb
    begin
        sum_red   = '0;
        sum_green = '0;
        sum_blue  = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (ctl.row_mask[r] && ctl.col_mask[c])
                begin
                    sum_red   = sum_red   + bb3_pkg::SUM_W'(win[r][c].red);
                    sum_green = sum_green + bb3_pkg::SUM_W'(win[r][c].green);
                    sum_blue  = sum_blue  + bb3_pkg::SUM_W'(win[r][c].blue);
                end
            end
        end
        row_cnt = 2'($countones(ctl.row_mask));
        col_cnt = 2'($countones(ctl.col_mask));
        n_cnt   = bb3_pkg::CNT_W'(row_cnt) * bb3_pkg::CNT_W'(col_cnt);
    end

    // (2*sum + n) / (2n) by reciprocal multiply
    always_comb
    begin
        num_red    = {s1_red_reg, 1'b0}   + bb3_pkg::NUM_W'(s1_n_reg);
        num_green  = {s1_green_reg, 1'b0} + bb3_pkg::NUM_W'(s1_n_reg);
        num_blue   = {s1_blue_reg, 1'b0}  + bb3_pkg::NUM_W'(s1_n_reg);
        prod_red   = bb3_pkg::PROD_W'(num_red)   * bb3_pkg::PROD_W'(s1_recip_reg);
        prod_green = bb3_pkg::PROD_W'(num_green) * bb3_pkg::PROD_W'(s1_recip_reg);
        prod_blue  = bb3_pkg::PROD_W'(num_blue)  * bb3_pkg::PROD_W'(s1_recip_reg);
    end

    assign out_load = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                s1_valid_reg <= 1'b1;
            else if (out_load)
                s1_valid_reg <= 1'b0;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_red_reg   <= sum_red;
            s1_green_reg <= sum_green;
            s1_blue_reg  <= sum_blue;
            s1_n_reg     <= n_cnt;
            s1_recip_reg <= bb3_pkg::recip(n_cnt);
            s1_last_reg  <= ctl.last;
        end
        if (out_load)
        begin
            out_red_reg   <= prod_red[bb3_pkg::RECIP_SHIFT +: 8];
            out_green_reg <= prod_green[bb3_pkg::RECIP_SHIFT +: 8];
            out_blue_reg  <= prod_blue[bb3_pkg::RECIP_SHIFT +: 8];
            out_last_reg  <= s1_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_red    = out_red_reg;
    assign out_green  = out_green_reg;
    assign out_blue   = out_blue_reg;
    assign frame_last = out_last_reg;

endmodule

// File: rtl/core/box_blur_3x3_rgb_unit.sv
// A pixel result passes the pixel stage, then the sum and divide stages of bb3_mean.
// Throughput: one pixel item per cycle unless a drain runs or the pixel stage stalls;
// the line store read at acceptance and its write-back as the stage retires overlap,
// with forwarding when both hit one column. A drain from the store holds the input over
// three reads of the single read port and its result; a window drain, its result.
// Reset clears positions, counters and handshake state; the line store is not cleared.
module box_blur_3x3_rgb_unit #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input items
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             opcode,
    input  logic [7:0]                       in_red,
    input  logic [7:0]                       in_green,
    input  logic [7:0]                       in_blue,
    // result items
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       out_red,
    output logic [7:0]                       out_green,
    output logic [7:0]                       out_blue,
    output logic                             frame_last
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = (AW > bb3_pkg::WIDTH_W) ? AW : bb3_pkg::WIDTH_W;
    localparam int HW = bb3_pkg::HEIGHT_W;
    localparam int PW = bb3_pkg::PEND_W;

    // One line store entry: the column of the row two back and of the row one back
    typedef struct packed {
        bb3_pkg::pixel_t two_back;
        bb3_pkg::pixel_t one_back;
    } line_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DR_READ,
        ST_DR_LAST,
        ST_DR_WIN
    } state_t;

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    logic [bb3_pkg::WIDTH_W-1:0] cfg_width_reg;
    logic [HW-1:0]               cfg_height_reg;

    logic [AW-1:0]               in_col_reg, out_col_reg;
    logic [HW-1:0]               in_row_reg, out_row_reg;
    logic [PW-1:0]               pending_reg;

    state_t                      state_reg;
    logic [1:0]                  dk_reg;
    logic [AW-1:0]               d_col_reg;
    bb3_pkg::pixel_t [1:0][1:0]  dtmp_reg;

    // Pixel stage: line store data returns here, window shifts, store writes back
    logic                        p_valid_reg;
    logic                        p_emit_reg;
    logic                        p_pre_reg;
    logic [AW-1:0]               p_col_reg;
    bb3_pkg::pixel_t             p_px_reg;

    logic                        fwd_reg;
    line_t                       fwd_data_reg;

    bb3_pkg::mean_ctl_t          ctl_reg;
    bb3_pkg::window_t            win_reg;

    line_t                       line_mem [MAX_WIDTH];
    line_t                       rd_data_reg;

    // ---------------------------------------------------------------------
    // Combinational signals
    // ---------------------------------------------------------------------
    logic [bb3_pkg::WIDTH_W-1:0] eff_w;
    logic [HW-1:0]               eff_h;
    logic [CW-1:0]               w_m1;
    logic [HW-1:0]               h_m1;
    logic [PW-1:0]               w_p1;

    logic                        cfg_fire, in_fire, pix_fire;
    logic                        at_frame_start, pend_nz, discard, pix_emit, drain_go;
    logic [PW-1:0]               pend_eff;
    logic [AW-1:0]               ocol_eff, ocol_nx, icol_nx;
    logic [HW-1:0]               orow_eff, orow_nx, irow_nx;
    logic                        out_last_row, out_last_col;
    logic [2:0]                  row_mask, cc1_mask, cc2_mask;
    bb3_pkg::mean_ctl_t          ctl_next;

    logic                        p_go;
    logic                        mem_re, mem_we;
    logic [AW-1:0]               rd_addr;
    line_t                       rd_eff, wr_data;
    bb3_pkg::pixel_t [2:0]       col_new;
    bb3_pkg::window_t            shw, dwin;

    logic                        mean_valid, mean_ready;
    bb3_pkg::window_t            mean_win;

    // Width clamped to 1..MAX_WIDTH, height to at least 1
    always_comb
    begin
        if (cfg_width_reg == '0)
            eff_w = bb3_pkg::WIDTH_W'(1);
        else if ({20'd0, cfg_width_reg} > 32'(MAX_WIDTH))
            eff_w = bb3_pkg::WIDTH_W'(MAX_WIDTH);
        else
            eff_w = cfg_width_reg;
        eff_h = (cfg_height_reg == '0) ? HW'(1) : cfg_height_reg;
        w_m1  = CW'(eff_w) - CW'(1);
        h_m1  = eff_h - HW'(1);
        w_p1  = {1'b0, eff_w} + PW'(1);
    end

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && in_ready;
    assign pix_fire  = in_fire && (opcode == bb3_pkg::OP_PIXEL);

    // Output position bookkeeping for the item at the input
    always_comb
    begin
        at_frame_start = (in_col_reg == '0) && (in_row_reg == '0);
        pend_nz        = (pending_reg != '0);
        // a pixel that opens a frame drops a partly flushed tail of the last one
        discard        = (opcode == bb3_pkg::OP_PIXEL) && at_frame_start && pend_nz
                         && (pending_reg <= {1'b0, eff_w});
        drain_go       = at_frame_start && pend_nz;
        pend_eff       = discard ? '0 : pending_reg;
        ocol_eff       = discard ? '0 : out_col_reg;
        orow_eff       = discard ? '0 : out_row_reg;
        pix_emit       = (pend_eff == w_p1);

        out_last_row   = (orow_eff == h_m1);
        out_last_col   = (CW'(ocol_eff) == w_m1);
        row_mask       = {!out_last_row, 1'b1, orow_eff != '0};
        // centre in the middle column, or in the newest column
        cc1_mask       = {!out_last_col, 1'b1, ocol_eff != '0};
        cc2_mask       = {1'b1, ocol_eff != '0, 1'b0};

        if (out_last_col)
        begin
            ocol_nx = '0;
            orow_nx = out_last_row ? '0 : orow_eff + HW'(1);
        end
        else
        begin
            ocol_nx = ocol_eff + AW'(1);
            orow_nx = orow_eff;
        end

        if (CW'(in_col_reg) == w_m1)
        begin
            icol_nx = '0;
            irow_nx = (in_row_reg == h_m1) ? '0 : in_row_reg + HW'(1);
        end
        else
        begin
            icol_nx = in_col_reg + AW'(1);
            irow_nx = in_row_reg;
        end

        ctl_next.row_mask = row_mask;
        ctl_next.last     = out_last_row && out_last_col;
        if (opcode == bb3_pkg::OP_PIXEL)
            ctl_next.col_mask = (in_col_reg == '0) ? cc2_mask : cc1_mask;
        else
            ctl_next.col_mask = out_last_row ? cc1_mask : cc2_mask;
    end

    // Line store access: read at acceptance or during a drain, write from the pixel stage
    assign p_go    = p_valid_reg && (!p_emit_reg || mean_ready);
    assign mem_re  = pix_fire || (state_reg == ST_DR_READ);
    assign mem_we  = p_go;
    assign rd_addr = (state_reg == ST_DR_READ) ? d_col_reg + AW'(dk_reg) - AW'(1)
                                               : in_col_reg;
    assign rd_eff  = fwd_reg ? fwd_data_reg : rd_data_reg;

    always_comb
    begin
        col_new[0] = rd_eff.two_back;
        col_new[1] = rd_eff.one_back;
        col_new[2] = p_px_reg;
        for (int r = 0; r < 3; r++)
        begin
            shw[r][0] = win_reg[r][1];
            shw[r][1] = win_reg[r][2];
            shw[r][2] = col_new[r];
        end
        // drain of the last row: two stored rows, bottom row outside the frame
        dwin[0][0] = dtmp_reg[0][0];
        dwin[0][1] = dtmp_reg[0][1];
        dwin[0][2] = rd_data_reg.two_back;
        dwin[1][0] = dtmp_reg[1][0];
        dwin[1][1] = dtmp_reg[1][1];
        dwin[1][2] = rd_data_reg.one_back;
        dwin[2]    = '0;
        wr_data.two_back = rd_eff.one_back;
        wr_data.one_back = p_px_reg;
    end

    // Select what the mean unit sees
    always_comb
    begin
        priority if (p_valid_reg)
        begin
            mean_valid = p_emit_reg;
            mean_win   = p_pre_reg ? win_reg : shw;
        end
        else if (state_reg == ST_DR_LAST)
        begin
            mean_valid = 1'b1;
            mean_win   = dwin;
        end
        else if (state_reg == ST_DR_WIN)
        begin
            mean_valid = 1'b1;
            mean_win   = win_reg;
        end
        else
        begin
            mean_valid = 1'b0;
            mean_win   = win_reg;
        end
    end

    assign in_ready = (state_reg == ST_IDLE) && (!p_valid_reg || p_go);

    // ---------------------------------------------------------------------
    // Control state and drain sequencer
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= bb3_pkg::RESET_WIDTH;
            cfg_height_reg <= bb3_pkg::RESET_HEIGHT;
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            pending_reg    <= '0;
            state_reg      <= ST_IDLE;
            dk_reg         <= '0;
            p_valid_reg    <= 1'b0;
            p_emit_reg     <= 1'b0;
            fwd_reg        <= 1'b0;
        end
        else
        begin
            // retire the pixel stage
            if (p_go)
            begin
                p_valid_reg <= 1'b0;
                fwd_reg     <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                end
                ST_DR_READ:
                begin
                    dk_reg <= dk_reg + 2'd1;
                    if (dk_reg == 2'd2)
                        state_reg <= ST_DR_LAST;
                end
                ST_DR_LAST, ST_DR_WIN:
                begin
                    if (mean_ready)
                        state_reg <= ST_IDLE;
                end
            endcase

            if (cfg_fire)
            begin
                // any known register restarts the frame
                if (cfg_index == bb3_pkg::REG_FRAME_WIDTH ||
                    cfg_index == bb3_pkg::REG_FRAME_HEIGHT)
                begin
                    if (cfg_index == bb3_pkg::REG_FRAME_WIDTH)
                        cfg_width_reg <= cfg_data[bb3_pkg::WIDTH_W-1:0];
                    else
                        cfg_height_reg <= cfg_data;
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                    pending_reg <= '0;
                end
            end
            else if (in_fire)
            begin
                unique case (opcode)
                    bb3_pkg::OP_PIXEL:
                    begin
                        if (pix_emit)
                        begin
                            pending_reg <= pend_eff;
                            out_col_reg <= ocol_nx;
                            out_row_reg <= orow_nx;
                        end
                        else
                        begin
                            pending_reg <= pend_eff + PW'(1);
                            out_col_reg <= ocol_eff;
                            out_row_reg <= orow_eff;
                        end
                        in_col_reg  <= icol_nx;
                        in_row_reg  <= irow_nx;
                        p_valid_reg <= 1'b1;
                        p_emit_reg  <= pix_emit;
                        // the stage retiring now writes the column this read wants
                        fwd_reg     <= p_valid_reg && (p_col_reg == in_col_reg);
                    end
                    bb3_pkg::OP_DRAIN:
                    begin
                        if (drain_go)
                        begin
                            pending_reg <= pending_reg - PW'(1);
                            out_col_reg <= ocol_nx;
                            out_row_reg <= orow_nx;
                            dk_reg      <= '0;
                            state_reg   <= out_last_row ? ST_DR_READ : ST_DR_WIN;
                        end
                    end
                endcase
            end
        end
    end

    // ---------------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            p_px_reg     <= {in_red, in_green, in_blue};
            p_col_reg    <= in_col_reg;
            p_pre_reg    <= (in_col_reg == '0);
            fwd_data_reg <= wr_data;
        end
        if (in_fire)
        begin
            ctl_reg   <= ctl_next;
            d_col_reg <= out_col_reg;
        end
        if (p_go)
            win_reg <= shw;
        // advance the drain columns as store reads return
        if (state_reg == ST_DR_READ)
        begin
            dtmp_reg[0][0] <= dtmp_reg[0][1];
            dtmp_reg[0][1] <= rd_data_reg.two_back;
            dtmp_reg[1][0] <= dtmp_reg[1][1];
            dtmp_reg[1][1] <= rd_data_reg.one_back;
        end
    end

    // Line store: both earlier rows in one word, one read and one write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[p_col_reg] <= wr_data;
        if (mem_re)
            rd_data_reg <= line_mem[rd_addr];
    end

    bb3_mean u_mean (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (mean_valid),
        .in_ready   (mean_ready),
        .win        (mean_win),
        .ctl        (ctl_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .frame_last (frame_last)
    );

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= w_p1)
        else $error("outputs owed exceed one row plus one");

    a_in_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(in_col_reg) <= w_m1)
        else $error("input column beyond frame width");

    a_stage_excl: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> state_reg == ST_IDLE)
        else $error("pixel stage busy during a drain");

    a_fwd_stage: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> p_valid_reg)
        else $error("forwarded store data without a pixel in the stage");

    a_drain_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DR_READ && dk_reg == 2'd2) |=> state_reg == ST_DR_LAST)
        else $error("drain did not finish after three store reads");

endmodule
